>>> rtl/nfs_pkg.sv
// ----------------------------------------------------------------------------
// nfs_pkg: shared types and codes of the fcfs / sjf scheduler
// Command and result words, queue entry and queue control struct.
// ----------------------------------------------------------------------------
package nfs_pkg;

  // command codes
  localparam logic FUNC_ARRIVE = 1'b0;
  localparam logic FUNC_TICK   = 1'b1;

  // result status codes
  localparam logic [1:0] ST_QUEUED  = 2'd0;
  localparam logic [1:0] ST_DROPPED = 2'd1;
  localparam logic [1:0] ST_TICK    = 2'd2;

  // configuration port
  localparam int unsigned ADDR_W = 3;
  localparam logic REG_POLICY = 1'b0;  // word index of policy_mode

  // policy codes
  localparam logic POLICY_FCFS = 1'b0;
  localparam logic POLICY_SJF  = 1'b1;

  typedef struct packed {
    logic       func;
    logic [7:0] task_id;
    logic [7:0] task_duration;
  } cmd_t;

  typedef struct packed {
    logic [1:0] status;
    logic       running_valid;
    logic [7:0] running_id;
    logic       finished_valid;
    logic [7:0] finished_id;
    logic [4:0] ready_count;
  } res_t;

  typedef struct packed {
    logic [7:0] id;
    logic [7:0] dur;
  } entry_t;

  typedef struct packed {
    logic ins;   // insert new entry this cycle
    logic pop;   // remove head this cycle
    logic mode;  // ordering policy
  } q_ctrl_t;

endpackage

>>> rtl/nfs_cell.sv
// ----------------------------------------------------------------------------
// nfs_cell: one slot of the shift-register ready queue
// Holds one entry, takes its left neighbor on insert-shift and its right
// neighbor on pop, and passes the insertion-point flag to the right.
// ----------------------------------------------------------------------------
module nfs_cell (
  input  logic            clk_i,
  input  logic            occ_i,
  input  logic            found_i,
  input  nfs_pkg::q_ctrl_t ctrl_i,
  input  nfs_pkg::entry_t new_i,
  input  nfs_pkg::entry_t left_i,
  input  nfs_pkg::entry_t right_i,
  output nfs_pkg::entry_t entry_o,
  output logic            found_o
);
  import nfs_pkg::*;

  entry_t entry_q, entry_d;
  logic   cmp;
  logic   hit;

  // insertion point: first empty slot, or first larger duration in sjf mode
  assign cmp     = occ_i & (ctrl_i.mode == POLICY_SJF) & (entry_q.dur > new_i.dur);
  assign hit     = ~occ_i | cmp;
  assign found_o = found_i | hit;

  // slot update
  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.pop) begin
      entry_d = right_i;
    end else if (ctrl_i.ins) begin
      if (found_i) begin
        entry_d = left_i;
      end else if (hit) begin
        entry_d = new_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

>>> rtl/nfs_queue.sv
// ----------------------------------------------------------------------------
// nfs_queue: ready queue built as a row of cells
// Keeps the fill count; slots below the count are occupied.
// ----------------------------------------------------------------------------
module nfs_queue #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  nfs_pkg::q_ctrl_t ctrl_i,
  input  nfs_pkg::entry_t  new_i,
  output nfs_pkg::entry_t  head_o,
  output logic [CNT_W-1:0] count_o,
  output logic             full_o
);
  import nfs_pkg::*;

  entry_t           entries [QUEUE_DEPTH];
  logic             found   [QUEUE_DEPTH+1];
  logic [CNT_W-1:0] count_q, count_d;

  assign found[0] = 1'b0;

  // row of cells
  for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
    entry_t left_w, right_w;
    logic   occ_w;
    assign occ_w   = CNT_W'(k) < count_q;
    assign left_w  = (k == 0) ? new_i : entries[(k == 0) ? 0 : k - 1];
    assign right_w = (k == QUEUE_DEPTH - 1) ? entries[k]
                                            : entries[(k == QUEUE_DEPTH - 1) ? k : k + 1];
    nfs_cell u_cell (
      .clk_i   (clk_i),
      .occ_i   (occ_w),
      .found_i (found[k]),
      .ctrl_i  (ctrl_i),
      .new_i   (new_i),
      .left_i  (left_w),
      .right_i (right_w),
      .entry_o (entries[k]),
      .found_o (found[k+1])
    );
  end

  // fill count
  always_comb begin
    count_d = count_q;
    if (ctrl_i.pop) begin
      count_d = count_q - CNT_W'(1);
    end else if (ctrl_i.ins) begin
      count_d = count_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign head_o  = entries[0];
  assign count_o = count_q;
  assign full_o  = count_q == CNT_W'(QUEUE_DEPTH);

endmodule

>>> rtl/nonpreemptive_fcfs_sjf_scheduler.sv
// ----------------------------------------------------------------------------
// nonpreemptive_fcfs_sjf_scheduler: single-processor task scheduler
// Result: one result word per accepted command, on done_o in the next cycle.
// Throughput: one command per cycle; busy stays low, and the queue row
// inserts or pops as each command is taken.
// Reset: queue empty, processor idle, policy first come first served.
// ----------------------------------------------------------------------------
module nonpreemptive_fcfs_sjf_scheduler #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  nfs_pkg::cmd_t              cmd_i,
  output logic                       done_o,
  output nfs_pkg::res_t              res_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [nfs_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import nfs_pkg::*;

  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic             mode_q;
  logic             busy_q, busy_d;
  logic [7:0]       cur_id_q, cur_id_d;
  logic [7:0]       cur_len_q, cur_len_d;
  logic [7:0]       exec_q, exec_d;
  logic             done_q;
  res_t             res_q, res_d;
  q_ctrl_t          q_ctrl;
  entry_t           new_entry, head;
  logic [CNT_W-1:0] count;
  logic             full;
  logic             accept, is_tick, finish, dispatch, ins_ok;
  logic [CNT_W-1:0] count_after;

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_POLICY) ? {31'b0, mode_q} : 32'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= POLICY_FCFS;
    end else if (psel && penable && pwrite && paddr[2] == REG_POLICY) begin
      mode_q <= pwdata[0];
    end
  end

  // command decode
  assign busy      = 1'b0;
  assign accept    = start & ~busy;
  assign is_tick   = cmd_i.func == FUNC_TICK;
  assign finish    = busy_q & (exec_q >= cur_len_q);
  assign dispatch  = accept & is_tick & (~busy_q | finish) & (count != '0);
  assign ins_ok    = accept & ~is_tick & ~full;
  assign new_entry = '{id: cmd_i.task_id, dur: cmd_i.task_duration};

  assign q_ctrl = '{ins: ins_ok, pop: dispatch, mode: mode_q};

  nfs_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .CNT_W       (CNT_W)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (q_ctrl),
    .new_i   (new_entry),
    .head_o  (head),
    .count_o (count),
    .full_o  (full)
  );

  // processor state
  always_comb begin
    busy_d    = busy_q;
    cur_id_d  = cur_id_q;
    cur_len_d = cur_len_q;
    exec_d    = exec_q;
    if (accept && is_tick) begin
      if (dispatch) begin
        busy_d    = 1'b1;
        cur_id_d  = head.id;
        cur_len_d = head.dur;
        exec_d    = 8'd1;
      end else if (finish) begin
        busy_d = 1'b0;
      end else if (busy_q && exec_q != 8'hFF) begin
        exec_d = exec_q + 8'd1;
      end
    end
  end

  // result word
  always_comb begin
    count_after = count;
    if (ins_ok) begin
      count_after = count + CNT_W'(1);
    end else if (dispatch) begin
      count_after = count - CNT_W'(1);
    end
    res_d.ready_count = 5'(count_after);
    if (is_tick) begin
      res_d.status         = ST_TICK;
      res_d.running_valid  = busy_d;
      res_d.running_id     = busy_d ? cur_id_d : 8'd0;
      res_d.finished_valid = finish;
      res_d.finished_id    = finish ? cur_id_q : 8'd0;
    end else begin
      res_d.status         = full ? ST_DROPPED : ST_QUEUED;
      res_d.running_valid  = busy_q;
      res_d.running_id     = busy_q ? cur_id_q : 8'd0;
      res_d.finished_valid = 1'b0;
      res_d.finished_id    = 8'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      cur_id_q  <= '0;
      cur_len_q <= '0;
      exec_q    <= '0;
      done_q    <= 1'b0;
    end else begin
      busy_q    <= busy_d;
      cur_id_q  <= cur_id_d;
      cur_len_q <= cur_len_d;
      exec_q    <= exec_d;
      done_q    <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule
